// ===== hw/rtl/knn_pkg.sv =====
// Shared types and constants for the k-nearest-neighbor search block.
`default_nettype none

package knn_pkg;

    // Number of parallel scan lanes; entries are interleaved across them.
    localparam int LANES = 4;
    localparam int LANE_W = 2;

    // Width of a neighbor count, enough for k up to 63.
    localparam int K_CNT_W = 6;

    // Cycles from the last scan read until every lane list holds its final value.
    localparam int DRAIN_CYCLES = 3;
    localparam int DRAIN_W = 2;

    // Fixed field widths of the ports.
    localparam int KIND_W = 2;
    localparam int FEAT_IN_W = 8;
    localparam int IDX_OUT_W = 8;
    localparam int DIST_OUT_W = 18;
    localparam int CFG_W = 4;

    // Request kinds on the input channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } knn_kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE
    } knn_state_t;

    // Command from the sequencer to the merging stage.
    typedef struct packed {
        logic               start;
        logic               empty;
        logic [K_CNT_W-1:0] filled;
    } knn_merge_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/knn_lane.sv =====
// One scan lane: a bank of stored points, a distance pipeline and a sorted best list.
`default_nettype none

module knn_lane #(
    parameter int MAX_K      = 8,
    parameter int FEAT_BITS  = 8,
    parameter int BANK_DEPTH = 64,
    parameter int ADDR_W     = 6,
    parameter int LANE_ID    = 0
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   wr_en,
    input  wire logic [ADDR_W-1:0]                      wr_addr,
    input  wire logic [3*FEAT_BITS-1:0]                 wr_point,
    input  wire logic                                   rd_en,
    input  wire logic [ADDR_W-1:0]                      rd_addr,
    input  wire logic [3*FEAT_BITS-1:0]                 query,
    input  wire logic [knn_pkg::K_CNT_W-1:0]            k,
    input  wire logic                                   clear,
    input  wire logic                                   pop,
    output logic                                        head_valid,
    output logic [2*FEAT_BITS+1:0]                      head_dist,
    output logic [ADDR_W+knn_pkg::LANE_W-1:0]           head_idx
);
    import knn_pkg::*;

    localparam int DIST_W = 2 * FEAT_BITS + 2;
    localparam int SQ_W   = 2 * FEAT_BITS;
    localparam int EIDX_W = ADDR_W + LANE_W;

    // Point bank.
    logic [3*FEAT_BITS-1:0] bank [BANK_DEPTH];

    // Pipeline registers.
    logic [3*FEAT_BITS-1:0] rd_data_reg;
    logic                   s1_valid_reg;
    logic [ADDR_W-1:0]      s1_row_reg;
    logic [SQ_W-1:0]        sq_reg [3];
    logic [SQ_W-1:0]        sq_next [3];
    logic                   s2_valid_reg;
    logic [ADDR_W-1:0]      s2_row_reg;
    logic [DIST_W-1:0]      s3_dist_reg;
    logic                   s3_valid_reg;
    logic [ADDR_W-1:0]      s3_row_reg;

    // Sorted best list, slot 0 nearest.
    logic                   list_valid_reg [MAX_K];
    logic                   list_valid_next [MAX_K];
    logic [DIST_W-1:0]      list_dist_reg [MAX_K];
    logic [DIST_W-1:0]      list_dist_next [MAX_K];
    logic [EIDX_W-1:0]      list_idx_reg [MAX_K];
    logic [EIDX_W-1:0]      list_idx_next [MAX_K];
    logic                   take [MAX_K];
    logic                   take_prev [MAX_K];
    logic [EIDX_W-1:0]      cand_idx;

    // Bank write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank[wr_addr] <= wr_point;
        end
        if (rd_en) begin
            rd_data_reg <= bank[rd_addr];
        end
    end

    // Squared coordinate differences.
    always_comb begin
        logic [FEAT_BITS-1:0] qa;
        logic [FEAT_BITS-1:0] pa;
        logic [FEAT_BITS-1:0] diff;
        for (int j = 0; j < 3; j++) begin
            qa   = query[(3-j)*FEAT_BITS-1 -: FEAT_BITS];
            pa   = rd_data_reg[(3-j)*FEAT_BITS-1 -: FEAT_BITS];
            diff = (qa >= pa) ? (qa - pa) : (pa - qa);
            sq_next[j] = SQ_W'(diff) * SQ_W'(diff);
        end
    end

    // Distance pipeline payload.
    always_ff @(posedge aclk) begin
        s1_row_reg <= rd_addr;
        for (int j = 0; j < 3; j++) begin
            sq_reg[j] <= sq_next[j];
        end
        s2_row_reg  <= s1_row_reg;
        s3_dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        s3_row_reg  <= s2_row_reg;
    end

    // Distance pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Slots that the new candidate displaces; a strict compare keeps earlier ties ahead.
    assign cand_idx = {s3_row_reg, LANE_W'(LANE_ID)};

    always_comb begin
        for (int p = 0; p < MAX_K; p++) begin
            take[p] = (K_CNT_W'(p) < k) &&
                      (!list_valid_reg[p] || (list_dist_reg[p] > s3_dist_reg));
        end
        take_prev[0] = 1'b0;
        for (int p = 1; p < MAX_K; p++) begin
            take_prev[p] = take[p-1];
        end
    end

    // List update: clear, pop to the merging stage, or insert a candidate.
    always_comb begin
        for (int p = 0; p < MAX_K; p++) begin
            list_valid_next[p] = list_valid_reg[p];
            list_dist_next[p]  = list_dist_reg[p];
            list_idx_next[p]   = list_idx_reg[p];
        end
        if (clear) begin
            for (int p = 0; p < MAX_K; p++) begin
                list_valid_next[p] = 1'b0;
            end
        end else if (pop) begin
            for (int p = 0; p < MAX_K - 1; p++) begin
                list_valid_next[p] = list_valid_reg[p+1];
                list_dist_next[p]  = list_dist_reg[p+1];
                list_idx_next[p]   = list_idx_reg[p+1];
            end
            list_valid_next[MAX_K-1] = 1'b0;
        end else if (s3_valid_reg) begin
            for (int p = 1; p < MAX_K; p++) begin
                if (take[p] && take_prev[p]) begin
                    list_valid_next[p] = list_valid_reg[p-1];
                    list_dist_next[p]  = list_dist_reg[p-1];
                    list_idx_next[p]   = list_idx_reg[p-1];
                end
            end
            for (int p = 0; p < MAX_K; p++) begin
                if (take[p] && !take_prev[p]) begin
                    list_valid_next[p] = 1'b1;
                    list_dist_next[p]  = s3_dist_reg;
                    list_idx_next[p]   = cand_idx;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_K; p++) begin
                list_valid_reg[p] <= 1'b0;
            end
        end else begin
            for (int p = 0; p < MAX_K; p++) begin
                list_valid_reg[p] <= list_valid_next[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int p = 0; p < MAX_K; p++) begin
            list_dist_reg[p] <= list_dist_next[p];
            list_idx_reg[p]  <= list_idx_next[p];
        end
    end

    // Head of the list goes to the merging stage.
    assign head_valid = list_valid_reg[0];
    assign head_dist  = list_dist_reg[0];
    assign head_idx   = list_idx_reg[0];

endmodule

`default_nettype wire

// ===== hw/rtl/knn_merge.sv =====
// Merging stage: picks the nearest lane head each step and holds the result register.
`default_nettype none

module knn_merge #(
    parameter int DIST_W = 18,
    parameter int EIDX_W = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire knn_pkg::knn_merge_cmd_t                cmd,
    input  wire logic                                   head_valid [knn_pkg::LANES],
    input  wire logic [DIST_W-1:0]                      head_dist [knn_pkg::LANES],
    input  wire logic [EIDX_W-1:0]                      head_idx [knn_pkg::LANES],
    output logic                                        pop [knn_pkg::LANES],
    output logic                                        busy,
    input  wire logic                                   m_ready,
    output logic                                        m_valid,
    output logic                                        m_found,
    output logic [knn_pkg::IDX_OUT_W-1:0]               m_entry_index,
    output logic [knn_pkg::DIST_OUT_W-1:0]              m_distance_sq,
    output logic                                        m_last
);
    import knn_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic               empty_reg;
    logic [K_CNT_W-1:0] filled_reg;
    logic [K_CNT_W-1:0] sent_reg;
    logic [K_CNT_W-1:0] sent_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_found_reg;
    logic [IDX_OUT_W-1:0]  m_index_reg;
    logic [DIST_OUT_W-1:0] m_dist_reg;
    logic               m_last_reg;
    logic               step;
    logic               is_last;
    logic [LANE_W-1:0]  win;
    logic [DIST_W-1:0]  win_dist;
    logic [EIDX_W-1:0]  win_idx;

    // Nearest head across lanes; lower index wins a tie.
    always_comb begin
        logic found_any;
        found_any = 1'b0;
        win       = '0;
        win_dist  = head_dist[0];
        win_idx   = head_idx[0];
        for (int l = 0; l < LANES; l++) begin
            if (head_valid[l] && (!found_any || (head_dist[l] < win_dist) ||
                    ((head_dist[l] == win_dist) && (head_idx[l] < win_idx)))) begin
                found_any = 1'b1;
                win       = LANE_W'(l);
                win_dist  = head_dist[l];
                win_idx   = head_idx[l];
            end
        end
    end

    // While busy, a step fills the result register whenever it is free or being emptied.
    assign step    = busy_reg && (!m_valid_reg || m_ready);
    assign is_last = empty_reg || ((sent_reg + K_CNT_W'(1)) == filled_reg);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            pop[l] = step && !empty_reg && (win == LANE_W'(l));
        end
    end

    // Control next values.
    always_comb begin
        busy_next    = busy_reg;
        sent_next    = sent_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.start) begin
            busy_next = 1'b1;
            sent_next = '0;
        end else if (step) begin
            m_valid_next = 1'b1;
            sent_next    = sent_reg + K_CNT_W'(1);
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            sent_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Command payload and result register.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            empty_reg  <= cmd.empty;
            filled_reg <= cmd.filled;
        end
        if (step) begin
            m_found_reg <= !empty_reg;
            m_index_reg <= empty_reg ? '0 : IDX_OUT_W'(win_idx);
            m_dist_reg  <= empty_reg ? '0 : DIST_OUT_W'(win_dist);
            m_last_reg  <= is_last;
        end
    end

    assign busy          = busy_reg;
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_entry_index = m_index_reg;
    assign m_distance_sq = m_dist_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/knn_top_k_search.sv =====
// Top level of the k-nearest-neighbor search: sequencer, four scan lanes and the merger.
`default_nettype none

// The block stores up to MAX_ENTRIES three-coordinate points and answers nearest-neighbor
// queries by squared Euclidean distance. A clear or load request produces no result; a
// load into a full store is dropped. A query on N stored points reads four points per
// cycle, one per lane bank, then lets the distance pipelines empty, and then reports
// min(k, N) neighbors in turn, holding whenever the result side does not take one.
// The input is ready again once the merger has gone idle after the last result has
// been loaded into the output register and the sequencer has returned to idle.
// Results come in ascending distance, equal distances in load order, with last set on
// the final one; a query on an empty store gives a single result with found clear.
// neighbor_count is taken as 1 when written as 0 and limited to MAX_K. Write it only
// while no query is in flight.

module knn_top_k_search #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_K       = 8,
    parameter int FEAT_BITS   = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [knn_pkg::CFG_W-1:0]          cfg_neighbor_count,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [knn_pkg::KIND_W-1:0]         s_kind,
    input  wire logic [knn_pkg::FEAT_IN_W-1:0]      s_feature_a,
    input  wire logic [knn_pkg::FEAT_IN_W-1:0]      s_feature_b,
    input  wire logic [knn_pkg::FEAT_IN_W-1:0]      s_feature_c,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_found,
    output logic [knn_pkg::IDX_OUT_W-1:0]           m_entry_index,
    output logic [knn_pkg::DIST_OUT_W-1:0]          m_distance_sq,
    output logic                                    m_last
);
    import knn_pkg::*;

    localparam int BANK_DEPTH = (MAX_ENTRIES + LANES - 1) / LANES;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int DIST_W     = 2 * FEAT_BITS + 2;
    localparam int EIDX_W     = ADDR_W + LANE_W;
    localparam int K_RESET    = (3 > MAX_K) ? MAX_K : 3;

    knn_state_t             state_reg;
    knn_state_t             state_next;
    logic [CNT_W-1:0]       entry_total_reg;
    logic [CNT_W-1:0]       entry_total_next;
    logic [K_CNT_W-1:0]     k_reg;
    logic [K_CNT_W-1:0]     cfg_k;
    logic [3*FEAT_BITS-1:0] query_reg;
    logic [3*FEAT_BITS-1:0] in_point;
    logic [ADDR_W-1:0]      row_reg;
    logic [ADDR_W-1:0]      row_next;
    logic [ADDR_W-1:0]      last_row;
    logic [DRAIN_W-1:0]     drain_reg;
    logic [DRAIN_W-1:0]     drain_next;
    logic                   accept;
    knn_kind_t              kind;
    logic                   wr_en;
    logic                   lane_clear;
    logic                   scan_en;
    logic [K_CNT_W-1:0]     filled;
    knn_merge_cmd_t         merge_cmd;
    logic                   merge_busy;

    logic                   lane_wr_en [LANES];
    logic                   lane_rd_en [LANES];
    logic                   head_valid [LANES];
    logic [DIST_W-1:0]      head_dist [LANES];
    logic [EIDX_W-1:0]      head_idx [LANES];
    logic                   lane_pop [LANES];

    // Request handshake and decoded fields.
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign kind      = knn_kind_t'(s_kind);
    assign in_point  = {FEAT_BITS'(s_feature_a), FEAT_BITS'(s_feature_b),
                        FEAT_BITS'(s_feature_c)};
    assign cfg_ready = 1'b1;

    // Neighbor count, forced into the range one to MAX_K on write.
    always_comb begin
        if (cfg_neighbor_count == '0) begin
            cfg_k = K_CNT_W'(1);
        end else if (cfg_neighbor_count > MAX_K) begin
            cfg_k = K_CNT_W'(MAX_K);
        end else begin
            cfg_k = K_CNT_W'(cfg_neighbor_count);
        end
    end

    // Scan bounds and the number of results a query reports.
    assign last_row = ADDR_W'((entry_total_reg - CNT_W'(1)) >> LANE_W);
    assign filled   = (entry_total_reg < k_reg) ? K_CNT_W'(entry_total_reg) : k_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (kind == KIND_QUERY)) begin
                    state_next = (entry_total_reg == '0) ? ST_MERGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (row_reg == last_row) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (!merge_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and counter updates.
    always_comb begin
        entry_total_next = entry_total_reg;
        row_next         = row_reg;
        drain_next       = drain_reg;
        wr_en            = 1'b0;
        lane_clear       = 1'b0;
        scan_en          = 1'b0;
        merge_cmd.start  = 1'b0;
        merge_cmd.empty  = 1'b0;
        merge_cmd.filled = filled;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_CLEAR: begin
                            entry_total_next = '0;
                        end
                        KIND_LOAD: begin
                            if (entry_total_reg < MAX_ENTRIES) begin
                                wr_en            = 1'b1;
                                entry_total_next = entry_total_reg + CNT_W'(1);
                            end
                        end
                        KIND_QUERY: begin
                            if (entry_total_reg == '0) begin
                                merge_cmd.start = 1'b1;
                                merge_cmd.empty = 1'b1;
                            end else begin
                                lane_clear = 1'b1;
                                row_next   = '0;
                            end
                        end
                        default: begin
                            entry_total_next = entry_total_reg;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                scan_en    = 1'b1;
                row_next   = row_reg + ADDR_W'(1);
                drain_next = '0;
            end
            ST_DRAIN: begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    merge_cmd.start = 1'b1;
                end
            end
            ST_MERGE: begin
                drain_next = '0;
            end
            default: begin
                drain_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_total_reg <= '0;
            k_reg           <= K_CNT_W'(K_RESET);
            row_reg         <= '0;
            drain_reg       <= '0;
        end else begin
            state_reg       <= state_next;
            entry_total_reg <= entry_total_next;
            row_reg         <= row_next;
            drain_reg       <= drain_next;
            if (cfg_valid && cfg_ready) begin
                k_reg <= cfg_k;
            end
        end
    end

    // Query point held for the whole scan.
    always_ff @(posedge aclk) begin
        if (accept) begin
            query_reg <= in_point;
        end
    end

    // Scan lanes; entry n lives in lane n mod LANES at row n / LANES.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        assign lane_wr_en[g] = wr_en && (entry_total_reg[LANE_W-1:0] == LANE_W'(g));
        assign lane_rd_en[g] = scan_en && ({row_reg, LANE_W'(g)} < entry_total_reg);

        knn_lane #(
            .MAX_K      (MAX_K),
            .FEAT_BITS  (FEAT_BITS),
            .BANK_DEPTH (BANK_DEPTH),
            .ADDR_W     (ADDR_W),
            .LANE_ID    (g)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr_en      (lane_wr_en[g]),
            .wr_addr    (ADDR_W'(entry_total_reg >> LANE_W)),
            .wr_point   (in_point),
            .rd_en      (lane_rd_en[g]),
            .rd_addr    (row_reg),
            .query      (query_reg),
            .k          (k_reg),
            .clear      (lane_clear),
            .pop        (lane_pop[g]),
            .head_valid (head_valid[g]),
            .head_dist  (head_dist[g]),
            .head_idx   (head_idx[g])
        );
    end

    // Merging stage and result register.
    knn_merge #(
        .DIST_W (DIST_W),
        .EIDX_W (EIDX_W)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (merge_cmd),
        .head_valid    (head_valid),
        .head_dist     (head_dist),
        .head_idx      (head_idx),
        .pop           (lane_pop),
        .busy          (merge_busy),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_found       (m_found),
        .m_entry_index (m_entry_index),
        .m_distance_sq (m_distance_sq),
        .m_last        (m_last)
    );

    // The merger must have finished before a new request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !merge_busy)
        else $error("merger busy while sequencer idle");

    // The point count never exceeds the store size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        entry_total_reg <= MAX_ENTRIES)
        else $error("point count beyond store size");

    // A load into a store with room adds exactly one point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (kind == KIND_LOAD) && (entry_total_reg < MAX_ENTRIES)) |=>
        (entry_total_reg == $past(entry_total_reg) + CNT_W'(1)))
        else $error("load did not add a point");

    // A no-neighbor result is the only and final result of its query.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_last && (m_entry_index == '0) && (m_distance_sq == '0)))
        else $error("malformed empty-store result");

endmodule

`default_nettype wire
